@@ src/scbb_pkg.sv @@
// Shared types, codes and constants of the servo command and drive block.
`timescale 1ns / 1ps
package scbb_pkg;

  // Position converter width; only the low SAMPLE_BITS of a sample are kept
  localparam int SAMPLE_BITS = 12;
  localparam int POS_W = 12;
  localparam logic [POS_W-1:0] SAMPLE_MASK =
    (SAMPLE_BITS >= POS_W) ? {POS_W{1'b1}} : POS_W'((1 << SAMPLE_BITS) - 1);

  // Configuration register indexes
  localparam logic [2:0] REG_DEADBAND  = 3'd0;
  localparam logic [2:0] REG_ANGLE_MIN = 3'd1;
  localparam logic [2:0] REG_ANGLE_MAX = 3'd2;
  localparam logic [2:0] REG_LEVEL_MIN = 3'd3;
  localparam logic [2:0] REG_LEVEL_MAX = 3'd4;

  // Configuration reset values
  localparam logic [9:0]  DEADBAND_RST  = 10'd25;
  localparam logic [11:0] ANGLE_MIN_RST = 12'd200;
  localparam logic [11:0] ANGLE_MAX_RST = 12'd4000;
  localparam logic [9:0]  LEVEL_MIN_RST = 10'd100;
  localparam logic [9:0]  LEVEL_MAX_RST = 10'd990;

  // State reset values
  localparam logic [11:0] TARGET_RST = 12'd200;
  localparam logic [9:0]  LEVEL_RST  = 10'd900;

  // Item operations
  localparam logic OP_BYTE   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Reply kinds
  localparam logic [2:0] KIND_DRIVE    = 3'd0;
  localparam logic [2:0] KIND_ANGLE    = 3'd1;
  localparam logic [2:0] KIND_LEVEL    = 3'd2;
  localparam logic [2:0] KIND_REPORT   = 3'd3;
  localparam logic [2:0] KIND_ENABLED  = 3'd4;
  localparam logic [2:0] KIND_DISABLED = 3'd5;

  // Characters
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_A       = 8'h41;
  localparam logic [7:0] CH_E       = 8'h45;
  localparam logic [7:0] CH_D       = 8'h44;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // Number parser phases
  localparam logic [1:0] PH_SKIP = 2'd0;
  localparam logic [1:0] PH_POS  = 2'd1;
  localparam logic [1:0] PH_NEG  = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  localparam int LINE_HEAD = 4;

  // Control from the line tracker to one number parser
  typedef struct packed {
    logic step;    // a byte transfer is committed this cycle
    logic active;  // the byte lies inside this parser's field
    logic eol;     // the byte is the newline
  } parse_ctl_t;

endpackage

@@ src/scbb_if.sv @@
// Input item and reply channel interfaces.
`timescale 1ns / 1ps
interface scbb_item_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [7:0]  rx_byte;
  logic [11:0] position_sample;

  modport source (output valid, operation, rx_byte, position_sample, input ready);
  modport sink (input valid, operation, rx_byte, position_sample, output ready);
endinterface

interface scbb_reply_if;
  logic        valid;
  logic        ready;
  logic [2:0]  reply_kind;
  logic [11:0] reply_value;
  logic [9:0]  drive_fwd;
  logic [9:0]  drive_rev;

  modport source (output valid, reply_kind, reply_value, drive_fwd, drive_rev, input ready);
  modport sink (input valid, reply_kind, reply_value, drive_fwd, drive_rev, output ready);
endinterface

@@ src/scbb_num_parser.sv @@
// Decimal number reader in the style of atoi, saturating at 16 bits.
`timescale 1ns / 1ps
module scbb_num_parser (
  input  logic                clk,
  input  logic                rst,
  input  scbb_pkg::parse_ctl_t ctl,
  input  logic [7:0]          ch,
  output logic [15:0]         value
);
  import scbb_pkg::*;

  logic [1:0]  phase;
  logic [1:0]  phase_next;
  logic [15:0] acc;
  logic [15:0] acc_next;
  logic        digit;
  logic        blank;
  logic [15:0] dval;
  logic [19:0] prod;
  logic [15:0] finished;

  // Character classes and the multiply-by-ten accumulate
  assign digit = (ch inside {[8'h30:8'h39]});
  assign blank = (ch == CH_SPACE) || (ch inside {[8'h09:8'h0D]});
  assign dval  = {12'd0, ch[3:0]};
  assign prod  = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {4'd0, dval};

  // Value as seen at the end of the line: nonzero negative saturates
  assign finished = ((phase == PH_NEG) && (acc != 16'd0)) ? 16'hFFFF : acc;
  assign value    = finished;

  // Next phase and accumulator
  always_comb begin
    phase_next = phase;
    acc_next   = acc;
    if (ctl.eol) begin
      phase_next = PH_SKIP;
      acc_next   = 16'd0;
    end else if (ctl.active) begin
      case (phase)
        PH_SKIP: begin
          if (blank) begin
            phase_next = PH_SKIP;
          end else if (ch == CH_PLUS) begin
            phase_next = PH_POS;
          end else if (ch == CH_MINUS) begin
            phase_next = PH_NEG;
          end else if (digit) begin
            acc_next   = dval;
            phase_next = PH_POS;
          end else begin
            phase_next = PH_DONE;
          end
        end
        PH_POS, PH_NEG: begin
          if (digit) begin
            acc_next = (prod > 20'h0FFFF) ? 16'hFFFF : prod[15:0];
          end else begin
            acc_next   = finished;
            phase_next = PH_DONE;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SKIP;
      acc   <= 16'd0;
    end else if (ctl.step) begin
      phase <= phase_next;
      acc   <= acc_next;
    end
  end

endmodule

@@ src/servo_command_and_bang_bang_drive.sv @@
// Top level: servo command line decoder and bang-bang H-bridge drive.
//
//   port      dir   kind          carries
//   item      in    valid/ready   operation, rx_byte, position_sample
//   reply     out   valid/ready   reply_kind, reply_value, drive_fwd, drive_rev
//   cfg_*     in    write only    cfg_we, cfg_index, cfg_data (12 bits)
//
// One item per cycle unless the reply stalls; an item goes through the input register,
// then one pass of decode, parse and compare into the reply register.
// The multiply-by-ten accumulate of the number parsers sets the critical path.
// Synchronous reset sets valid flags, controller state and configuration to defaults.
// A stalled reply holds the pipeline; items keep flowing while the reply slot drains.
`timescale 1ns / 1ps
module servo_command_and_bang_bang_drive (
  input  logic        clk,
  input  logic        rst,
  scbb_item_if.sink   item,
  scbb_reply_if.source reply,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data
);
  import scbb_pkg::*;

  // Configuration
  logic [9:0]  deadband;
  logic [11:0] angle_min;
  logic [11:0] angle_max;
  logic [9:0]  level_min;
  logic [9:0]  level_max;

  // Input register
  logic        s1_valid;
  logic        s1_op;
  logic [7:0]  s1_byte;
  logic [11:0] s1_sample;
  logic        advance;

  // Controller state
  logic [11:0] target_angle;
  logic [9:0]  drive_level;
  logic        motion_enabled;
  logic [11:0] last_position;
  logic [2:0]  line_position;
  logic [7:0]  head_chars [LINE_HEAD];

  // Reply register
  logic        out_valid;
  logic [2:0]  out_kind;
  logic [11:0] out_value;
  logic [9:0]  out_fwd;
  logic [9:0]  out_rev;

  // Pass results
  logic        res_valid;
  logic [2:0]  res_kind;
  logic [11:0] res_value;
  logic [9:0]  res_fwd;
  logic [9:0]  res_rev;
  logic [11:0] target_next;
  logic [9:0]  level_next;
  logic        enabled_next;

  logic        byte_step;
  logic        is_nl;
  logic [7:0]  head_eff [LINE_HEAD];
  logic [11:0] pos;
  logic [12:0] hi_edge;
  logic [12:0] pos_plus_db;
  logic [15:0] angle_val;
  logic [15:0] level_val;
  logic [15:0] angle_lo;
  logic [15:0] level_lo;
  logic        d0;
  logic        d1;
  logic        d2;
  parse_ctl_t  angle_ctl;
  parse_ctl_t  level_ctl;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      deadband  <= DEADBAND_RST;
      angle_min <= ANGLE_MIN_RST;
      angle_max <= ANGLE_MAX_RST;
      level_min <= LEVEL_MIN_RST;
      level_max <= LEVEL_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEADBAND:  deadband  <= cfg_data[9:0];
        REG_ANGLE_MIN: angle_min <= cfg_data;
        REG_ANGLE_MAX: angle_max <= cfg_data;
        REG_LEVEL_MIN: level_min <= cfg_data[9:0];
        REG_LEVEL_MAX: level_max <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  // Handshake: the pass commits when the reply slot is free or draining
  assign advance    = s1_valid && (!out_valid || reply.ready);
  assign item.ready = !s1_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_op     <= item.operation;
      s1_byte   <= item.rx_byte;
      s1_sample <= item.position_sample;
    end
  end

  // Number parsers: angle from the second byte on, level from the third
  assign byte_step = advance && (s1_op == OP_BYTE);
  assign is_nl     = (s1_byte == CH_NL);

  assign angle_ctl = '{step: byte_step, active: (line_position >= 3'd1), eol: is_nl};
  assign level_ctl = '{step: byte_step, active: (line_position >= 3'd2), eol: is_nl};

  scbb_num_parser u_angle_parser (
    .clk   (clk),
    .rst   (rst),
    .ctl   (angle_ctl),
    .ch    (s1_byte),
    .value (angle_val)
  );

  scbb_num_parser u_level_parser (
    .clk   (clk),
    .rst   (rst),
    .ctl   (level_ctl),
    .ch    (s1_byte),
    .value (level_val)
  );

  // Line head as it stands once the current byte is stored
  always_comb begin
    for (int i = 0; i < LINE_HEAD; i++) begin
      head_eff[i] = (line_position == 3'(i)) ? s1_byte : head_chars[i];
    end
  end

  assign d0 = (head_eff[0] == CH_DOLLAR);
  assign d1 = (head_eff[1] == CH_DOLLAR);
  assign d2 = (head_eff[2] == CH_DOLLAR);

  // Clamp: raise to the minimum, then lower to the maximum
  assign angle_lo = (angle_val < {4'd0, angle_min}) ? {4'd0, angle_min} : angle_val;
  assign level_lo = (level_val < {6'd0, level_min}) ? {6'd0, level_min} : level_val;

  // Window edges, kept unsigned: below window means pos + deadband < target
  assign pos         = s1_sample & SAMPLE_MASK;
  assign hi_edge     = {1'b0, target_angle} + {3'd0, deadband};
  assign pos_plus_db = {1'b0, pos} + {3'd0, deadband};

  // Decode one item into a reply and the next controller state
  always_comb begin
    res_valid    = 1'b0;
    res_kind     = KIND_DRIVE;
    res_value    = 12'd0;
    res_fwd      = 10'd0;
    res_rev      = 10'd0;
    target_next  = target_angle;
    level_next   = drive_level;
    enabled_next = motion_enabled;
    if (s1_op == OP_SAMPLE) begin
      if (motion_enabled) begin
        res_valid = 1'b1;
        if ({1'b0, pos} > hi_edge) begin
          res_fwd = drive_level;
        end else if (pos_plus_db < {1'b0, target_angle}) begin
          res_rev = drive_level;
        end
      end
    end else if (is_nl) begin
      if (d0 && !d1 && !d2) begin
        target_next = (angle_lo > {4'd0, angle_max}) ? angle_max : angle_lo[11:0];
        res_valid   = 1'b1;
        res_kind    = KIND_ANGLE;
        res_value   = target_next;
      end else if (d0 && d1 && !d2) begin
        level_next = (level_lo > {6'd0, level_max}) ? level_max : level_lo[9:0];
        res_valid  = 1'b1;
        res_kind   = KIND_LEVEL;
        res_value  = {2'd0, level_next};
      end else if (d0 && d1 && d2) begin
        if (head_eff[3] == CH_A) begin
          res_valid = 1'b1;
          res_kind  = KIND_REPORT;
          res_value = last_position;
        end else if (head_eff[3] == CH_E) begin
          enabled_next = 1'b1;
          res_valid    = 1'b1;
          res_kind     = KIND_ENABLED;
          res_value    = 12'd1;
        end else if (head_eff[3] == CH_D) begin
          enabled_next = 1'b0;
          res_valid    = 1'b1;
          res_kind     = KIND_DISABLED;
        end
      end
    end
  end

  // Controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      target_angle   <= TARGET_RST;
      drive_level    <= LEVEL_RST;
      motion_enabled <= 1'b0;
      last_position  <= 12'd0;
      line_position  <= 3'd0;
      for (int i = 0; i < LINE_HEAD; i++) begin
        head_chars[i] <= 8'd0;
      end
    end else if (advance) begin
      target_angle   <= target_next;
      drive_level    <= level_next;
      motion_enabled <= enabled_next;
      if (s1_op == OP_SAMPLE) begin
        last_position <= pos;
      end else begin
        if (line_position < 3'(LINE_HEAD)) begin
          head_chars[line_position[1:0]] <= s1_byte;
        end
        if (is_nl) begin
          line_position <= 3'd0;
        end else if (line_position < 3'(LINE_HEAD)) begin
          line_position <= line_position + 3'd1;
        end
      end
    end
  end

  // Reply register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end else if (reply.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_kind  <= res_kind;
      out_value <= res_value;
      out_fwd   <= res_fwd;
      out_rev   <= res_rev;
    end
  end

  assign reply.valid       = out_valid;
  assign reply.reply_kind  = out_kind;
  assign reply.reply_value = out_value;
  assign reply.drive_fwd   = out_fwd;
  assign reply.drive_rev   = out_rev;

  // Checks
  a_one_channel: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_kind == KIND_DRIVE)) |-> ((out_fwd == 10'd0) || (out_rev == 10'd0)))
    else $error("both bridge channels driven");

  a_quiet_drive: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_kind != KIND_DRIVE)) |-> ((out_fwd == 10'd0) && (out_rev == 10'd0)))
    else $error("drive duty on a command reply");

  a_line_sat: assert property (@(posedge clk) disable iff (rst)
    line_position <= 3'(LINE_HEAD))
    else $error("line position beyond head");

  a_nl_rewind: assert property (@(posedge clk) disable iff (rst)
    (byte_step && is_nl) |=> (line_position == 3'd0))
    else $error("newline did not rewind line position");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the servo command decoder and bang-bang drive.
`timescale 1ns / 1ps
module testbench;
  import scbb_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_REPORTS    = 10;
  localparam int unsigned ACC_MAX = 65535;

  // Blank characters besides space, and the digit range
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_VT   = 8'h0B;
  localparam logic [7:0] CH_FF   = 8'h0C;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  typedef struct packed {
    logic [2:0]  kind;
    logic [11:0] value;
    logic [9:0]  fwd;
    logic [9:0]  rev;
  } reply_t;

  // Servo command/drive predictor plus queue of replies still owed by the block
  class reply_scoreboard;
    logic [9:0]  deadband;
    logic [11:0] angle_lo, angle_hi;
    logic [9:0]  level_lo, level_hi;
    logic [11:0] target;
    logic [9:0]  level;
    bit          motion_on;
    logic [11:0] last_sample;
    int unsigned line_idx;
    logic [7:0]  line_head [4];
    logic [1:0]  num_phase [2];   // 0 angle number, 1 level number
    int unsigned num_acc [2];
    reply_t      expected_replies [$];
    int          errors;
    int          checked;
    int          items;
    int          kind_seen [6];

    function new();
      deadband = DEADBAND_RST;
      angle_lo = ANGLE_MIN_RST;
      angle_hi = ANGLE_MAX_RST;
      level_lo = LEVEL_MIN_RST;
      level_hi = LEVEL_MAX_RST;
      target = TARGET_RST;
      level = LEVEL_RST;
      motion_on = 1'b0;
      last_sample = '0;
      line_idx = 0;
      foreach (line_head[i]) line_head[i] = '0;
      foreach (num_phase[i]) begin
        num_phase[i] = PH_SKIP;
        num_acc[i] = 0;
      end
    endfunction

    function void write_reg(logic [2:0] idx, logic [11:0] data);
      case (idx)
        REG_DEADBAND:  deadband = data[9:0];
        REG_ANGLE_MIN: angle_lo = data;
        REG_ANGLE_MAX: angle_hi = data;
        REG_LEVEL_MIN: level_lo = data[9:0];
        REG_LEVEL_MAX: level_hi = data[9:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    // Negative nonzero numbers saturate so that they clamp to the maximum
    function void close_number(int p);
      if (num_phase[p] == PH_NEG && num_acc[p] != 0) num_acc[p] = ACC_MAX;
      num_phase[p] = PH_DONE;
    endfunction

    // atoi-style reader: blanks, optional sign, digits, anything else ends it
    function void feed_number(int p, logic [7:0] c);
      bit          digit;
      bit          blank;
      int unsigned v;
      digit = (c >= CH_ZERO) && (c <= CH_NINE);
      blank = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
      case (num_phase[p])
        PH_SKIP: begin
          if (!blank) begin
            if (c == CH_PLUS) num_phase[p] = PH_POS;
            else if (c == CH_MINUS) num_phase[p] = PH_NEG;
            else if (digit) begin
              num_acc[p] = c - CH_ZERO;
              num_phase[p] = PH_POS;
            end else num_phase[p] = PH_DONE;
          end
        end
        PH_POS, PH_NEG: begin
          if (digit) begin
            v = num_acc[p] * 10 + (c - CH_ZERO);
            num_acc[p] = (v > ACC_MAX) ? ACC_MAX : v;
          end else close_number(p);
        end
        default: ;
      endcase
    endfunction

    // Raise to the minimum first, then lower to the maximum
    function int unsigned clamp_to(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      return v;
    endfunction

    // Work out the reply, if any, of one accepted item
    function void note_item(logic op, logic [7:0] ch, logic [11:0] smp);
      int          hi_edge, lo_edge;
      int unsigned idx;
      reply_t      r;
      bit          d0, d1, d2, emit;
      items++;
      r = '0;
      if (op == OP_SAMPLE) begin
        last_sample = smp & SAMPLE_MASK;
        if (!motion_on) return;
        hi_edge = int'(target) + int'(deadband);
        lo_edge = int'(target) - int'(deadband);
        r.kind = KIND_DRIVE;
        if (int'(last_sample) > hi_edge) r.fwd = level;
        else if (int'(last_sample) < lo_edge) r.rev = level;
        expected_replies.push_back(r);
        return;
      end

      idx = line_idx;
      if (idx < LINE_HEAD) line_head[idx] = ch;
      if (ch != CH_NL) begin
        if (idx >= 1) feed_number(0, ch);
        if (idx >= 2) feed_number(1, ch);
        if (line_idx < LINE_HEAD) line_idx++;
        return;
      end

      // End of line: close both numbers and decode the line head
      close_number(0);
      close_number(1);
      d0 = line_head[0] == CH_DOLLAR;
      d1 = line_head[1] == CH_DOLLAR;
      d2 = line_head[2] == CH_DOLLAR;
      emit = 1'b1;
      if (d0 && !d1 && !d2) begin
        target = 12'(clamp_to(num_acc[0], angle_lo, angle_hi));
        r.kind = KIND_ANGLE;
        r.value = target;
      end else if (d0 && d1 && !d2) begin
        level = 10'(clamp_to(num_acc[1], level_lo, level_hi));
        r.kind = KIND_LEVEL;
        r.value = 12'(level);
      end else if (d0 && d1 && d2 && line_head[3] == CH_A) begin
        r.kind = KIND_REPORT;
        r.value = last_sample;
      end else if (d0 && d1 && d2 && line_head[3] == CH_E) begin
        motion_on = 1'b1;
        r.kind = KIND_ENABLED;
        r.value = 12'd1;
      end else if (d0 && d1 && d2 && line_head[3] == CH_D) begin
        motion_on = 1'b0;
        r.kind = KIND_DISABLED;
      end else emit = 1'b0;
      if (emit) expected_replies.push_back(r);

      line_idx = 0;
      foreach (num_phase[i]) begin
        num_phase[i] = PH_SKIP;
        num_acc[i] = 0;
      end
    endfunction

    // Compare one reply transfer with the oldest expected reply
    function void check_reply(reply_t got);
      reply_t exp_r;
      if (expected_replies.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("Unexpected reply: kind %0d value %0d fwd %0d rev %0d",
                   got.kind, got.value, got.fwd, got.rev);
        return;
      end
      exp_r = expected_replies.pop_front();
      checked++;
      if (exp_r.kind < 6) kind_seen[exp_r.kind]++;
      if (got.kind !== exp_r.kind || got.value !== exp_r.value ||
          got.fwd !== exp_r.fwd || got.rev !== exp_r.rev) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("Reply %0d mismatch (exp/got): kind %0d/%0d value %0d/%0d fwd %0d/%0d rev %0d/%0d",
                   checked, exp_r.kind, got.kind, exp_r.value, got.value,
                   exp_r.fwd, got.fwd, exp_r.rev, got.rev);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [11:0] cfg_data;

  scbb_item_if  item_ch ();
  scbb_reply_if reply_ch ();

  servo_command_and_bang_bang_drive dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .reply     (reply_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  reply_scoreboard sb;
  logic [7:0]      line_buf [$];
  bit              sender_calm;
  bit              hold_req;
  int              items_sent;
  int              config_phases;
  int              quiet_cycles;

  always #CLK_HALF clk = ~clk;

  // Monitor both channels and watch for a stuck handshake
  always @(posedge clk) begin : monitor
    reply_t got;
    if (!rst) begin
      if (item_ch.valid && item_ch.ready)
        sb.note_item(item_ch.operation, item_ch.rx_byte, item_ch.position_sample);
      if (reply_ch.valid && reply_ch.ready) begin
        got.kind = reply_ch.reply_kind;
        got.value = reply_ch.reply_value;
        got.fwd = reply_ch.drive_fwd;
        got.rev = reply_ch.drive_rev;
        sb.check_reply(got);
      end
      if ((item_ch.valid && item_ch.ready) || (reply_ch.valid && reply_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles, %0d replies outstanding",
                 quiet_cycles, sb.pending());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Reply sink: random runs of ready/stall, plus one long hold-off on request
  initial begin : reply_sink
    int   hold_left;
    int   run_left;
    logic run_val;
    int   r;
    hold_left = 0;
    run_left = 0;
    run_val = 1'b1;
    reply_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) reply_ch.ready <= 1'b0;
      else begin
        if (hold_req) begin
          hold_req = 1'b0;
          hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
          hold_left--;
          reply_ch.ready <= 1'b0;
        end else begin
          if (run_left == 0) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin run_val = 1'b1; run_left = $urandom_range(1, 20); end
            else if (r < 45) begin run_val = 1'b1; run_left = $urandom_range(80, 200); end
            else if (r < 85) begin run_val = 1'b0; run_left = $urandom_range(1, 3); end
            else if (r < 97) begin run_val = 1'b0; run_left = $urandom_range(4, 12); end
            else begin run_val = 1'b0; run_left = $urandom_range(20, 60); end
          end
          reply_ch.ready <= run_val;
          run_left--;
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (sender_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Samples cluster around the deadband edges, with full-range and extreme values
  function automatic logic [11:0] pick_sample();
    int r, v;
    r = $urandom_range(0, 99);
    if (r < 40) return 12'($urandom_range(0, 4095));
    if (r < 45) return 12'd0;
    if (r < 50) return 12'hFFF;
    v = int'(sb.target) - int'(sb.deadband) - 2 + int'($urandom_range(0, 2 * sb.deadband + 4));
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return 12'(v);
  endfunction

  // One item transfer; the unused field carries random bits
  task automatic send_item(logic op, logic [7:0] ch, logic [11:0] smp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.operation <= op;
    item_ch.rx_byte <= ch;
    item_ch.position_sample <= smp;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    items_sent++;
  endtask

  task automatic send_sample(logic [11:0] smp);
    send_item(OP_SAMPLE, 8'($urandom_range(0, 255)), smp);
  endtask

  // Send line_buf, optionally with samples slipped in between bytes
  task automatic send_line(bit mix);
    foreach (line_buf[i]) begin
      if (mix && $urandom_range(0, 11) == 0) send_sample(pick_sample());
      send_item(OP_BYTE, line_buf[i], 12'($urandom_range(0, 4095)));
    end
  endtask

  task automatic send_text(string s);
    line_buf.delete();
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    send_line(1'b0);
  endtask

  // Number text: optional blanks, optional sign, zero to seven digits
  function automatic void append_number();
    int r, n;
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 2))
        case ($urandom_range(0, 4))
          0: line_buf.push_back(CH_SPACE);
          1: line_buf.push_back(CH_TAB);
          2: line_buf.push_back(CH_VT);
          3: line_buf.push_back(CH_FF);
          default: line_buf.push_back(CH_CR);
        endcase
    r = $urandom_range(0, 99);
    if (r < 15) line_buf.push_back(CH_PLUS);
    else if (r < 30) line_buf.push_back(CH_MINUS);
    r = $urandom_range(0, 99);
    n = (r < 5) ? 0 : (r < 80) ? $urandom_range(1, 4) : $urandom_range(5, 7);
    repeat (n) line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endfunction

  // Mostly well-formed commands with random content; some noise and sample bursts
  task automatic random_line();
    int r;
    line_buf.delete();
    sender_calm = ($urandom_range(0, 6) == 0);
    r = $urandom_range(0, 99);
    if (r < 10) begin
      repeat ($urandom_range(1, 6)) send_sample(pick_sample());
      return;
    end
    if (r < 20) begin
      repeat ($urandom_range(0, 7)) line_buf.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) != 0) line_buf.push_back(CH_NL);
    end else begin
      if (r < 45) begin
        line_buf.push_back(CH_DOLLAR);
        append_number();
      end else if (r < 62) begin
        repeat (2) line_buf.push_back(CH_DOLLAR);
        append_number();
      end else begin
        repeat (3) line_buf.push_back(CH_DOLLAR);
        if (r < 72) line_buf.push_back(CH_A);
        else if (r < 86) line_buf.push_back(CH_E);
        else if (r < 93) line_buf.push_back(CH_D);
        else line_buf.push_back(8'($urandom_range(8'h21, 8'h7E)));
      end
      if ($urandom_range(0, 5) == 0)
        repeat ($urandom_range(1, 4)) line_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
      line_buf.push_back(CH_NL);
    end
    send_line(1'b1);
  endtask

  task automatic run_random(int count);
    int start;
    start = items_sent;
    while (items_sent - start < count) random_line();
    sender_calm = 1'b0;
  endtask

  // Stop sending, wait for every owed reply, then let the pipeline empty
  task automatic wait_idle();
    item_ch.valid <= 1'b0;
    // let the monitor note the last transfer first
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(int db, int amin, int amax, int lmin, int lmax);
    logic [2:0] idx [5];
    int         vals [5];
    idx = '{REG_DEADBAND, REG_ANGLE_MIN, REG_ANGLE_MAX, REG_LEVEL_MIN, REG_LEVEL_MAX};
    vals = '{db, amin, amax, lmin, lmax};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= 12'(vals[i]);
      @(posedge clk);
      sb.write_reg(idx[i], 12'(vals[i]));
    end
    cfg_we <= 1'b0;
    config_phases++;
  endtask

  // Stimulus sequence
  initial begin : stimulus
    int amin;
    sb = new();
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_DEADBAND;
    cfg_data <= '0;
    item_ch.valid <= 1'b0;
    item_ch.operation <= OP_BYTE;
    item_ch.rx_byte <= '0;
    item_ch.position_sample <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Default settings: every command, sample handling and number corner cases
    send_sample(12'hFFF);               // disabled: position kept, no reply
    send_text("$$$A\n");
    send_text("$$$E\n");
    send_sample(12'd226);
    send_sample(12'd225);
    send_sample(12'd175);
    send_sample(12'd174);
    send_sample(12'd0);
    send_text("$ \t+1234\n");
    send_text("$-7\n");
    send_text("$-0\n");
    send_text("$99999999\n");
    send_text("$\n");
    send_text("$$50\n");
    send_text("$$1000\n");
    send_text("$$ -3x\n");
    send_text("$$$Axyz\n");
    send_text("zz\n");
    send_text("\n");
    send_text("$$$D\n");
    send_sample(12'd3000);
    run_random(170);
    wait_idle();

    // Widest limits, no deadband
    write_config(0, 0, 4095, 0, 1000);
    send_text("$0\n");
    send_text("$4095\n");
    send_text("$$0\n");
    send_text("$$1000\n");
    send_text("$$$E\n");
    send_text("$2048\n");
    send_sample(12'd2047);
    send_sample(12'd2048);
    send_sample(12'd2049);
    run_random(150);
    wait_idle();

    // Minimums above maximums, deadband wider than the target
    write_config(1023, 3000, 100, 1000, 500);
    send_text("$50\n");
    send_text("$$7\n");
    send_text("$$$E\n");
    send_sample(12'd0);
    send_sample(12'd1123);
    send_sample(12'd1124);
    run_random(110);
    wait_idle();

    // Random limits; reply side held off while samples keep coming
    amin = $urandom_range(0, 2000);
    write_config($urandom_range(0, 300), amin, $urandom_range(amin, 4095),
                 $urandom_range(0, 500), $urandom_range(300, 1000));
    send_text("$$$E\n");
    hold_req = 1'b1;
    sender_calm = 1'b1;
    repeat (40) send_sample(pick_sample());
    sender_calm = 1'b0;
    run_random(190);
    wait_idle();

    $display("Run covered %0d items over %0d register settings; %0d replies checked, %0d errors",
             sb.items, config_phases + 1, sb.checked, sb.errors);
    $display("Replies by kind: drive %0d, angle %0d, level %0d, report %0d, on %0d, off %0d",
             sb.kind_seen[KIND_DRIVE], sb.kind_seen[KIND_ANGLE], sb.kind_seen[KIND_LEVEL],
             sb.kind_seen[KIND_REPORT], sb.kind_seen[KIND_ENABLED],
             sb.kind_seen[KIND_DISABLED]);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
